[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk with active-low rst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is held
`define RTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also holds during reset
`define RTE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/rte_pkg.sv]
// ---------------------------------------------------------------------------
// rte_pkg
// shared widths, register indexes and constants of the transposition encoder
// ---------------------------------------------------------------------------
package rte_pkg;

  localparam int DATA_W         = 8;
  localparam int KEY_LEN_W      = 4;
  localparam int KEY_BYTES      = 8;
  localparam int KEY_CHARS_W    = KEY_BYTES * DATA_W;
  localparam int CFG_DATA_W     = KEY_CHARS_W;
  localparam int CFG_IDX_W      = 2;

  localparam int RTE_MAX_KEY_LENGTH = 8;
  localparam int RTE_QUEUE_DEPTH    = 2;

  localparam logic [DATA_W-1:0] PAD_BYTE = 8'h58;  // 'X'

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS  = 2'd1;

  // row queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[hw/rtl/rte_stream_if.sv]
// ---------------------------------------------------------------------------
// rte_stream_if
// valid/ready channels for message bytes in and ciphertext bytes out
// ---------------------------------------------------------------------------
interface rte_in_if
  import rte_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rte_out_if
  import rte_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_byte;
  logic              last_in_run;
  logic              message_end;

  modport source (output valid, output out_byte, output last_in_run,
                  output message_end, input ready);
  modport sink   (input valid, input out_byte, input last_in_run,
                  input message_end, output ready);
endinterface

[hw/rtl/rte_front.sv]
// ---------------------------------------------------------------------------
// rte_front
// collects message bytes into a row, pads and hands complete rows on
// ---------------------------------------------------------------------------
module rte_front
  import rte_pkg::*;
#(
  parameter int COLS = RTE_MAX_KEY_LENGTH,
  parameter int CW   = $clog2(COLS),
  parameter int CNTW = $clog2(COLS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [DATA_W-1:0]      in_data_byte,
  input  logic                   in_last_byte,
  input  logic [CNTW-1:0]        eff_len,
  input  q_status_t              q_status,
  output logic                   push,
  output logic [COLS*DATA_W-1:0] row_bytes,
  output logic [CNTW-1:0]        row_len,
  output logic                   row_last
);

  logic [DATA_W-1:0] row_store_r [COLS];
  logic [CNTW-1:0]   fill_r, fill_nxt;
  logic [CW-1:0]     idx;
  logic [CNTW-1:0]   new_fill;
  logic              accept;
  logic              complete;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // a row left over from a longer key is dropped
  assign idx      = (fill_r >= eff_len) ? '0 : fill_r[CW-1:0];
  assign new_fill = CNTW'(idx) + CNTW'(1);
  assign complete = (new_fill >= eff_len) || in_last_byte;

  assign push     = accept && complete;
  assign row_len  = eff_len;
  assign row_last = in_last_byte;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      if (CW'(c) == idx) begin
        row_bytes[c*DATA_W +: DATA_W] = in_data_byte;
      end else if (CW'(c) < idx) begin
        row_bytes[c*DATA_W +: DATA_W] = row_store_r[c];
      end else begin
        row_bytes[c*DATA_W +: DATA_W] = PAD_BYTE;
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      fill_nxt = complete ? '0 : new_fill;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      row_store_r[idx] <= in_data_byte;
    end
  end

endmodule

[hw/rtl/rte_queue.sv]
// ---------------------------------------------------------------------------
// rte_queue
// short row queue between front and back, one push and one pop per cycle
// ---------------------------------------------------------------------------
module rte_queue
  import rte_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = RTE_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output q_status_t        status
);

  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int QCW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == QCW'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rd_data      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[hw/rtl/rte_back.sv]
// ---------------------------------------------------------------------------
// rte_back
// ranks the key columns and sends the head row out in column-rank order
// ---------------------------------------------------------------------------
module rte_back
  import rte_pkg::*;
#(
  parameter int COLS = RTE_MAX_KEY_LENGTH,
  parameter int CW   = $clog2(COLS),
  parameter int CNTW = $clog2(COLS + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [KEY_CHARS_W-1:0] key_chars,
  input  logic [CNTW-1:0]        eff_len,
  input  q_status_t              q_status,
  input  logic [COLS*DATA_W-1:0] row_bytes,
  input  logic [CNTW-1:0]        row_len,
  input  logic                   row_last,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [DATA_W-1:0]      out_byte,
  output logic                   out_last_in_run,
  output logic                   out_message_end
);

  logic [CW-1:0]     rank_r   [COLS];
  logic [CW-1:0]     rank_nxt [COLS];
  logic [CW-1:0]     col_r, col_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_byte_r;
  logic              out_last_r, out_end_r;
  logic              load;
  logic              run_end;
  logic [DATA_W-1:0] sel_byte;

  // rank of a column: lower keys, and equal keys further left, come first
  always_comb begin
    logic [CNTW-1:0] cnt;
    logic [DATA_W-1:0] kc;
    logic [DATA_W-1:0] kd;
    for (int c = 0; c < COLS; c++) begin
      cnt = '0;
      kc  = key_chars[c*DATA_W +: DATA_W];
      for (int d = 0; d < COLS; d++) begin
        kd = key_chars[d*DATA_W +: DATA_W];
        if ((CNTW'(d) < eff_len) && ((kd < kc) || ((kd == kc) && (d < c)))) begin
          cnt = cnt + CNTW'(1);
        end
      end
      rank_nxt[c] = cnt[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rank_r <= rank_nxt;
  end

  // pick the column whose rank matches the output position
  always_comb begin
    sel_byte = '0;
    for (int c = 0; c < COLS; c++) begin
      if ((CNTW'(c) < row_len) && (rank_r[c] == col_r)) begin
        sel_byte = sel_byte | row_bytes[c*DATA_W +: DATA_W];
      end
    end
  end

  assign load    = !q_status.empty && (!out_valid_r || out_ready);
  assign run_end = (CNTW'(col_r) == row_len - CNTW'(1));
  assign pop     = load && run_end;

  always_comb begin
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      col_nxt       = run_end ? '0 : col_r + CW'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= sel_byte;
      out_last_r <= run_end;
      out_end_r  <= run_end && row_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_in_run = out_last_r;
  assign out_message_end = out_end_r;

endmodule

[hw/rtl/row_transposition_encrypt_top.sv]
// ---------------------------------------------------------------------------
// row_transposition_encrypt_top
// streaming row transposition encoder with a two-row queue
// ---------------------------------------------------------------------------
// Message bytes arrive one per transfer on in_if and fill a row as wide as the
// key length (0 counts as 1, anything above the column count saturates). A full
// row, or the row that ends with last_byte (its tail padded with 'X'), leaves
// on out_if as one run of bytes in key order: columns ranked by key byte
// ascending, equal key bytes left to right. last_in_run marks the end of each
// run, message_end the end of the final run. Rate: the front takes one byte a
// cycle while the two-row queue has room; the back sends one byte a cycle from
// the head row through an output register unless out_ready holds it off. A row's
// first byte passes the queue and then the output register. Throughput is set by
// the back end's single output byte per cycle. The user must write key registers
// through cfg_we / cfg_index / cfg_wdata only while idle; the block does not enforce it.
// ---------------------------------------------------------------------------
module row_transposition_encrypt_top
  import rte_pkg::*;
#(
  parameter int MAX_KEY_LENGTH = RTE_MAX_KEY_LENGTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rte_in_if.sink                in_if,
  rte_out_if.source             out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // only eight key bytes exist, so the row never gets wider than that
  localparam int COLS   = (MAX_KEY_LENGTH < KEY_BYTES) ? MAX_KEY_LENGTH : KEY_BYTES;
  localparam int CW     = $clog2(COLS);
  localparam int CNTW   = $clog2(COLS + 1);
  localparam int QW     = COLS * DATA_W + CNTW + 1;

  // configuration registers
  logic [KEY_LEN_W-1:0]   key_length_r;
  logic [KEY_CHARS_W-1:0] key_chars_r;
  logic [CNTW-1:0]        eff_len;

  // front to queue
  logic                   q_push;
  logic [COLS*DATA_W-1:0] f_row_bytes;
  logic [CNTW-1:0]        f_row_len;
  logic                   f_row_last;

  // queue to back
  logic                   q_pop;
  logic [QW-1:0]          q_head;
  q_status_t              q_stat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r <= KEY_LEN_W'(1);
      key_chars_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_LENGTH: key_length_r <= cfg_wdata[KEY_LEN_W-1:0];
        CFG_KEY_CHARS:  key_chars_r  <= cfg_wdata[KEY_CHARS_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // effective row width: zero means one column, too large saturates
  always_comb begin
    if (key_length_r == '0) begin
      eff_len = CNTW'(1);
    end else if (key_length_r > KEY_LEN_W'(COLS)) begin
      eff_len = CNTW'(COLS);
    end else begin
      eff_len = CNTW'(key_length_r);
    end
  end

  rte_front #(
    .COLS (COLS),
    .CW   (CW),
    .CNTW (CNTW)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_if.valid),
    .in_ready     (in_if.ready),
    .in_data_byte (in_if.data_byte),
    .in_last_byte (in_if.last_byte),
    .eff_len      (eff_len),
    .q_status     (q_stat),
    .push         (q_push),
    .row_bytes    (f_row_bytes),
    .row_len      (f_row_len),
    .row_last     (f_row_last)
  );

  // each entry carries a padded row, its width and the message-end flag
  rte_queue #(
    .WIDTH (QW),
    .DEPTH (RTE_QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data ({f_row_last, f_row_len, f_row_bytes}),
    .pop     (q_pop),
    .rd_data (q_head),
    .status  (q_stat)
  );

  rte_back #(
    .COLS (COLS),
    .CW   (CW),
    .CNTW (CNTW)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .key_chars       (key_chars_r),
    .eff_len         (eff_len),
    .q_status        (q_stat),
    .row_bytes       (q_head[COLS*DATA_W-1:0]),
    .row_len         (q_head[COLS*DATA_W +: CNTW]),
    .row_last        (q_head[QW-1]),
    .pop             (q_pop),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_byte        (out_if.out_byte),
    .out_last_in_run (out_if.last_in_run),
    .out_message_end (out_if.message_end)
  );

  // checks
`include "assert_macros.svh"

  `RTE_ASSERT(a_push_has_room, q_push |-> !q_stat.full, "row pushed into a full queue")
  `RTE_ASSERT(a_pop_has_row, q_pop |-> !q_stat.empty, "row popped from an empty queue")
  `RTE_ASSERT(a_end_closes_run, (out_if.valid && out_if.message_end) |-> out_if.last_in_run, "message end inside a run")
  `RTE_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (q_stat.empty && !out_if.valid), "not empty after reset")

endmodule
